// ===== rtl/pprt_pkg.sv =====
// ----------------------------------------------------------------------------
// pprt_pkg
// Types and constants shared by the prefix/port rule table modules.
// ----------------------------------------------------------------------------
package pprt_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [5:0] MAX_PREFIX  = 6'd32;
  localparam logic [7:0] FORWARD_TAG = 8'h66;
  localparam logic [31:0] FULL_MASK  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic [7:0]  tag;
    logic [15:0] port;
  } in_item_t;

  typedef struct packed {
    logic       forward;
    logic       matched;
    logic [1:0] status;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the input item, reset scan results
    logic scan;   // examine the entry at the scan index
    logic commit; // apply the write or invalidation
    logic fetch;  // read the winning entry's payload
    logic done;   // present the result
  } pprt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
    logic bad_len;
    logic [1:0] opcode;
  } pprt_sts_t;

  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    m = '0;
    if (len == 6'd0) m = '0;
    else if (len >= MAX_PREFIX) m = FULL_MASK;
    else m = FULL_MASK << (MAX_PREFIX - len);
    return m;
  endfunction

endpackage

// ===== rtl/pprt_ctrl.sv =====
// ----------------------------------------------------------------------------
// pprt_ctrl
// Sequencer: load, scan every entry, commit, fetch payload on lookup, report.
// ----------------------------------------------------------------------------
module pprt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pprt_pkg::pprt_sts_t sts,
  output pprt_pkg::pprt_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_COMMIT = 6'b000100,
    S_FETCH  = 6'b001000,
    S_FETCH2 = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.bad_len && (sts.opcode == pprt_pkg::OP_ADD ||
                            sts.opcode == pprt_pkg::OP_CLEAR)) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan = 1'b1;
          if (sts.scan_last) state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = (sts.opcode == pprt_pkg::OP_LOOKUP) ? S_FETCH : S_DONE;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_FETCH2;
      end
      S_FETCH2: state_nxt = S_DONE;
      S_DONE: begin
        cmd.done = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== rtl/pprt_datapath.sv =====
// ----------------------------------------------------------------------------
// pprt_datapath
// Rule storage, one-entry-per-cycle scan and result formation.
// ----------------------------------------------------------------------------
module pprt_datapath #(
  parameter int RULE_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pprt_pkg::in_item_t   in_item,
  input  pprt_pkg::pprt_cmd_t  cmd,
  output pprt_pkg::pprt_sts_t  sts,
  output logic                 out_valid,
  output pprt_pkg::out_item_t  out_item
);

  localparam int IW = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
  localparam int CW = $clog2(RULE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST = CW'(RULE_ENTRIES - 1);

  // Length and network sit in memories read one entry ahead of the scan, so
  // the registered read data always belongs to the entry under compare. Port
  // range and tag sit in a memory read once per lookup.
  logic [RULE_ENTRIES-1:0] valid_r;
  logic [5:0]  len_mem  [RULE_ENTRIES];
  logic [31:0] net_mem  [RULE_ENTRIES];
  logic [39:0] pay_mem  [RULE_ENTRIES];
  logic [39:0] pay_rd_r;
  logic [5:0]  len_rd_r;
  logic [31:0] net_rd_r;

  pprt_pkg::in_item_t item_r;
  logic [CW-1:0] idx_r;
  logic [IW-1:0] idx, rd_idx;
  logic          best_ok_r, slot_ok_r, free_ok_r;
  logic [IW-1:0] best_r, slot_r, free_r;
  logic [5:0]    best_len_r, e_len;
  logic [31:0]   e_net, add_net;
  logic          hit, eq, fwd;
  logic [1:0]    status_r;

  assign idx    = idx_r[IW-1:0];
  assign rd_idx = (idx_r == LAST) ? '0 : IW'(idx_r + 1'b1);
  assign e_len  = len_rd_r;
  assign e_net  = net_rd_r;
  assign add_net = item_r.address & pprt_pkg::len_mask(item_r.prefix_len);
  assign hit = valid_r[idx] &&
               ((item_r.address & pprt_pkg::len_mask(e_len)) == e_net);
  assign eq  = valid_r[idx] && e_len == item_r.prefix_len && e_net == add_net;

  assign sts.scan_last = (idx_r == LAST);
  assign sts.bad_len   = (item_r.prefix_len > pprt_pkg::MAX_PREFIX);
  assign sts.opcode    = item_r.opcode;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
      idx_r <= '0;
      best_ok_r <= 1'b0; slot_ok_r <= 1'b0; free_ok_r <= 1'b0;
      best_len_r <= '0;
      len_rd_r <= len_mem[IW'(0)];
      net_rd_r <= net_mem[IW'(0)];
    end
    if (cmd.scan) begin
      idx_r <= idx_r + 1'b1;
      len_rd_r <= len_mem[rd_idx];
      net_rd_r <= net_mem[rd_idx];
      if (hit && (!best_ok_r || e_len > best_len_r)) begin
        best_ok_r <= 1'b1; best_r <= idx; best_len_r <= e_len;
      end
      if (eq && !slot_ok_r) begin
        slot_ok_r <= 1'b1; slot_r <= idx;
      end
      if (!valid_r[idx] && !free_ok_r) begin
        free_ok_r <= 1'b1; free_r <= idx;
      end
    end
    if (cmd.fetch) pay_rd_r <= pay_mem[best_r];
    if (cmd.commit && item_r.opcode == pprt_pkg::OP_ADD &&
        (slot_ok_r || free_ok_r)) begin
      len_mem[slot_ok_r ? slot_r : free_r] <= item_r.prefix_len;
      net_mem[slot_ok_r ? slot_r : free_r] <= add_net;
      pay_mem[slot_ok_r ? slot_r : free_r] <=
        {item_r.port_low, item_r.port_high, item_r.tag};
    end
  end

  // Valid bits: cleared at reset, set by add, dropped by remove and clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.scan && item_r.opcode == pprt_pkg::OP_CLEAR &&
          valid_r[idx] && e_len == item_r.prefix_len)
        valid_r[idx] <= 1'b0;
      if (cmd.commit) begin
        if (item_r.opcode == pprt_pkg::OP_ADD && (slot_ok_r || free_ok_r))
          valid_r[slot_ok_r ? slot_r : free_r] <= 1'b1;
        if (item_r.opcode == pprt_pkg::OP_REMOVE && best_ok_r)
          valid_r[best_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= pprt_pkg::ST_BAD_LEN;
    end else if (cmd.commit) begin
      status_r <= (item_r.opcode == pprt_pkg::OP_ADD && !slot_ok_r && !free_ok_r) ?
                  pprt_pkg::ST_FULL : pprt_pkg::ST_OK;
    end
  end

  always_comb begin
    fwd = item_r.opcode == pprt_pkg::OP_LOOKUP && best_ok_r &&
          item_r.port >= pay_rd_r[39:24] && item_r.port <= pay_rd_r[23:8] &&
          pay_rd_r[7:0] == pprt_pkg::FORWARD_TAG;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= cmd.done;
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      out_item.forward <= fwd;
      out_item.matched <= best_ok_r && (item_r.opcode == pprt_pkg::OP_LOOKUP ||
                                        item_r.opcode == pprt_pkg::OP_REMOVE);
      out_item.status  <= status_r;
    end
  end

endmodule

// ===== rtl/prefix_port_rule_table_unit.sv =====
// ----------------------------------------------------------------------------
// prefix_port_rule_table_unit
// IPv4 prefix rule table with port range and tag: add, lookup, remove, clear.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each item scans every
// rule slot, one per cycle, and busy stays high until the result is formed;
// the scan has a single compare port. A lookup also reads the payload of the
// winning rule, and an add or clear with a length above 32 skips the scan.
// Exactly one result follows each item: out_valid is high for one cycle with
// out_item, and the receiver cannot stall it. No clearing pass: the table is
// empty straight out of reset.
module prefix_port_rule_table_unit #(
  parameter int RULE_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pprt_pkg::in_item_t  in_item,
  output logic                out_valid,
  output pprt_pkg::out_item_t out_item
);

  pprt_pkg::pprt_cmd_t cmd;
  pprt_pkg::pprt_sts_t sts;

  // Sequence the scan
  pprt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  // Hold the rules, compare, report
  pprt_datapath #(.RULE_ENTRIES(RULE_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_item(out_item)
  );

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy) else $error("load while busy");
  a_result_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held two cycles");
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |-> busy) else $error("result without item");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives add, lookup, remove and clear items into the rule table, predicts
// each result from a local copy of the table and checks every result item.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RULE_ENTRIES = 64;
  localparam int STALL_LIMIT  = 2000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  pprt_pkg::in_item_t  in_item;
  logic                out_valid;
  pprt_pkg::out_item_t out_item;

  prefix_port_rule_table_unit #(.RULE_ENTRIES(RULE_ENTRIES)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  // Shadow copy of the rule table
  logic        rule_valid [RULE_ENTRIES];
  logic [5:0]  rule_len   [RULE_ENTRIES];
  logic [31:0] rule_net   [RULE_ENTRIES];
  logic [15:0] rule_plo   [RULE_ENTRIES];
  logic [15:0] rule_phi   [RULE_ENTRIES];
  logic [7:0]  rule_tag   [RULE_ENTRIES];

  pprt_pkg::in_item_t  pending_items[$];
  pprt_pkg::out_item_t expected_results[$];
  int        error_count;
  int        sent_count;
  int        result_count;
  int        forward_count;
  int        full_count;
  int        idle_pct;
  int        quiet_cycles;
  bit        hold_off;
  bit        stim_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    if (len == 6'd0) return 32'd0;
    if (len >= pprt_pkg::MAX_PREFIX) return pprt_pkg::FULL_MASK;
    return pprt_pkg::FULL_MASK << (6'd32 - len);
  endfunction

  // Longest valid prefix covering addr; lowest index wins a tie
  function automatic int best_rule(input logic [31:0] addr);
    int best;
    best = -1;
    for (int i = 0; i < RULE_ENTRIES; i++) begin
      if (rule_valid[i] && (addr & prefix_mask(rule_len[i])) == rule_net[i]) begin
        if (best < 0 || rule_len[i] > rule_len[best]) best = i;
      end
    end
    return best;
  endfunction

  // Apply one item to the shadow table and return its result
  function automatic pprt_pkg::out_item_t apply_rule_op(input pprt_pkg::in_item_t it);
    pprt_pkg::out_item_t r;
    logic [31:0] net;
    int          slot;
    int          free_slot;
    int          m;
    r = '0;
    case (it.opcode)
      pprt_pkg::OP_ADD: begin
        if (it.prefix_len > pprt_pkg::MAX_PREFIX) begin
          r.status = pprt_pkg::ST_BAD_LEN;
        end else begin
          net = it.address & prefix_mask(it.prefix_len);
          slot = -1;
          free_slot = -1;
          for (int i = 0; i < RULE_ENTRIES; i++) begin
            if (rule_valid[i]) begin
              if (slot < 0 && rule_len[i] == it.prefix_len && rule_net[i] == net) slot = i;
            end else if (free_slot < 0) begin
              free_slot = i;
            end
          end
          if (slot < 0) slot = free_slot;
          if (slot < 0) begin
            r.status = pprt_pkg::ST_FULL;
          end else begin
            rule_valid[slot] = 1'b1;
            rule_len[slot]   = it.prefix_len;
            rule_net[slot]   = net;
            rule_plo[slot]   = it.port_low;
            rule_phi[slot]   = it.port_high;
            rule_tag[slot]   = it.tag;
          end
        end
      end
      pprt_pkg::OP_LOOKUP: begin
        m = best_rule(it.address);
        if (m >= 0) begin
          r.matched = 1'b1;
          r.forward = it.port >= rule_plo[m] && it.port <= rule_phi[m] &&
                      rule_tag[m] == pprt_pkg::FORWARD_TAG;
        end
      end
      pprt_pkg::OP_REMOVE: begin
        m = best_rule(it.address);
        if (m >= 0) begin
          r.matched = 1'b1;
          rule_valid[m] = 1'b0;
        end
      end
      default: begin
        if (it.prefix_len > pprt_pkg::MAX_PREFIX) begin
          r.status = pprt_pkg::ST_BAD_LEN;
        end else begin
          for (int i = 0; i < RULE_ENTRIES; i++)
            if (rule_valid[i] && rule_len[i] == it.prefix_len) rule_valid[i] = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic pprt_pkg::in_item_t make_item(input logic [1:0] op,
      input logic [31:0] addr, input logic [5:0] len, input logic [15:0] plo,
      input logic [15:0] phi, input logic [7:0] tg, input logic [15:0] prt);
    pprt_pkg::in_item_t it;
    it = '{op, addr, len, plo, phi, tg, prt};
    return it;
  endfunction

  // Append an item to the tail of the pending queue
  task automatic add_pending(input pprt_pkg::in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // Addresses drawn from a small pool of networks so that rules overlap
  function automatic logic [31:0] pool_addr();
    logic [31:0] a;
    a = $urandom;
    case ($urandom_range(0, 3))
      0: a[31:24] = 8'd10;
      1: a[31:16] = 16'hC0A8;
      2: a[31:8]  = 24'h0A0001;
      default: ;
    endcase
    return a;
  endfunction

  function automatic pprt_pkg::in_item_t random_item();
    logic [1:0] op;
    logic [5:0] len;
    logic [15:0] plo;
    logic [15:0] prt;
    logic [7:0] tg;
    op  = $urandom_range(0, 9) < 4 ? pprt_pkg::OP_ADD : 2'($urandom_range(1, 3));
    if ($urandom_range(0, 9) == 0 && op == pprt_pkg::OP_REMOVE) op = pprt_pkg::OP_CLEAR;
    len = $urandom_range(0, 19) == 0 ? 6'($urandom_range(33, 63))
                                     : 6'($urandom_range(0, 32));
    if (op == pprt_pkg::OP_CLEAR && $urandom_range(0, 1)) len = 6'($urandom_range(0, 63));
    plo = $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2000));
    tg  = $urandom_range(0, 2) != 0 ? pprt_pkg::FORWARD_TAG : 8'($urandom);
    prt = $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4000));
    return make_item(op, pool_addr(), len, plo,
                     16'(plo + $urandom_range(0, 3000)) ^ ($urandom_range(0, 7) == 0 ?
                     16'($urandom) : 16'd0), tg, prt);
  endfunction

  // Driver: hold start until the item is taken, idling at random
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_item <= '0;
    end else if (!(start && busy)) begin
      if (start && !busy) begin
        expected_results.insert(expected_results.size(), apply_rule_op(in_item));
        sent_count++;
      end
      if (pending_items.size() > 0 && !hold_off && $urandom_range(0, 99) >= idle_pct) begin
        start   <= 1'b1;
        in_item <= pending_items.pop_front();
      end else begin
        start   <= 1'b0;
      end
    end
  end

  // Monitor: compare each result item with the oldest expectation
  always @(posedge clk) begin
    pprt_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_item), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_item.forward != want.forward)
          report_mismatch("forward", 32'(out_item.forward), 32'(want.forward));
        if (out_item.matched != want.matched)
          report_mismatch("matched", 32'(out_item.matched), 32'(want.matched));
        if (out_item.status != want.status)
          report_mismatch("status", 32'(out_item.status), 32'(want.status));
        if (want.forward) forward_count++;
        if (want.status == pprt_pkg::ST_FULL) full_count++;
      end
    end
  end

  // Watchdog: count cycles in which nothing is accepted and no result appears
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT && !stim_done) begin
      $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    idle_pct = 28; hold_off = 1'b0; stim_done = 1'b0;
    rst_n = 1'b0;
    for (int i = 0; i < RULE_ENTRIES; i++) rule_valid[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty lookup and remove, mask extremes, bad lengths
    add_pending(make_item(pprt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0, 16'hFFFF));
    add_pending(make_item(pprt_pkg::OP_REMOVE, '0, '0, '0, '0, '0, '0));
    add_pending(make_item(pprt_pkg::OP_ADD, 32'hFFFF_FFFF, '0, '0, 16'hFFFF,
                          pprt_pkg::FORWARD_TAG, '0));
    add_pending(make_item(pprt_pkg::OP_ADD, 32'hFFFF_FFFF, 6'd32, 16'd80, 16'd80,
                          pprt_pkg::FORWARD_TAG, '0));
    add_pending(make_item(pprt_pkg::OP_ADD, 32'h0A01_0203, 6'd33, '0, '0, '0, '0));
    add_pending(make_item(pprt_pkg::OP_ADD, 32'h0A01_0203, 6'd63, '0, '0, '0, '0));
    add_pending(make_item(pprt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0, 16'd80));
    add_pending(make_item(pprt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0, 16'd81));
    add_pending(make_item(pprt_pkg::OP_LOOKUP, 32'h1234_5678, '0, '0, '0, '0, 16'hFFFF));
    // Reversed range and a non-forward tag; then update in place
    add_pending(make_item(pprt_pkg::OP_ADD, 32'h0A00_0000, 6'd8, 16'd500, 16'd100,
                          pprt_pkg::FORWARD_TAG, '0));
    add_pending(make_item(pprt_pkg::OP_LOOKUP, 32'h0A55_0000, '0, '0, '0, '0, 16'd300));
    add_pending(make_item(pprt_pkg::OP_ADD, 32'h0AFF_FFFF, 6'd8, 16'd100, 16'd500,
                          8'h64, '0));
    add_pending(make_item(pprt_pkg::OP_LOOKUP, 32'h0A55_0000, '0, '0, '0, '0, 16'd300));
    add_pending(make_item(pprt_pkg::OP_ADD, 32'h0A00_0000, 6'd8, 16'd100, 16'd500,
                          pprt_pkg::FORWARD_TAG, '0));
    add_pending(make_item(pprt_pkg::OP_LOOKUP, 32'h0A55_0000, '0, '0, '0, '0, 16'd300));
    add_pending(make_item(pprt_pkg::OP_REMOVE, 32'h0A55_0000, '0, '0, '0, '0, '0));
    add_pending(make_item(pprt_pkg::OP_LOOKUP, 32'h0A55_0000, '0, '0, '0, '0, 16'd300));
    add_pending(make_item(pprt_pkg::OP_CLEAR, '0, 6'd40, '0, '0, '0, '0));
    add_pending(make_item(pprt_pkg::OP_CLEAR, '0, 6'd32, '0, '0, '0, '0));
    add_pending(make_item(pprt_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0));
    add_pending(make_item(pprt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0, 16'd80));

    // Fill the table to capacity, then overflow it
    for (int i = 0; i < RULE_ENTRIES + 2; i++)
      add_pending(make_item(pprt_pkg::OP_ADD, {16'hAC10, 16'(i)}, 6'd32, 16'($urandom),
                            16'($urandom), 8'($urandom), '0));
    add_pending(make_item(pprt_pkg::OP_LOOKUP, 32'hAC10_0005, '0, '0, '0, '0,
                          16'($urandom)));

    // Drain completely before the random part
    wait_drained();
    hold_off = 1'b1;
    repeat (10) @(posedge clk);
    hold_off = 1'b0;
    add_pending(make_item(pprt_pkg::OP_CLEAR, '0, 6'd32, '0, '0, '0, '0));

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = phase == 0 ? 28 : (phase == 1 ? 57 : 0);
      for (int n = 0; n < 120; n++) add_pending(random_item());
      wait_drained();
    end
    stim_done = 1'b1;
    repeat (100) @(posedge clk);

    $display("ran %0d items, %0d results, %0d forwarded, %0d table-full adds",
             sent_count, result_count, forward_count, full_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Hang guard for the end of the run
  initial begin
    #4000000;
    $display("run exceeded its time budget");
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pprt_pkg.sv
rtl/pprt_ctrl.sv
rtl/pprt_datapath.sv
rtl/prefix_port_rule_table_unit.sv
tb/testbench.sv
